### rtl/cnsm_pkg.sv
// Shared types, codes and filter coefficients for the colored noise shaper and mixer.
`timescale 1ns / 1ps

package cnsm_pkg;

	localparam int SAMPLE_WIDTH_DEF = 24;
	localparam int STATE_WIDTH_DEF  = 32;
	localparam int COEF_W           = 25;
	localparam int COEF_ONE         = 8388608;
	localparam int NUM_POLES        = 6;
	localparam int NUM_TAPS         = 7;
	localparam int BIAS_LIMIT       = 100;

	localparam logic [15:0] AMOUNT_MIN  = 16'd7;
	localparam logic [15:0] ALPHA_RESET = 16'd4025;

	localparam logic [1:0] COLOR_WHITE = 2'd0;
	localparam logic [1:0] COLOR_PINK  = 2'd1;
	localparam logic [1:0] COLOR_BROWN = 2'd2;

	typedef logic signed [COEF_W-1:0] coef_t;

	localparam coef_t POLE_COEF [NUM_POLES] = '{
		25'sd8379045, 25'sd8332572, 25'sd8128561,
		25'sd7268729, 25'sd4613734, -25'sd6388764
	};
	localparam coef_t FEED_COEF [NUM_POLES] = '{
		25'sd465718, 25'sd629782, 25'sd1290604,
		25'sd2604542, 25'sd4470727, -25'sd141751
	};
	localparam coef_t PINK_DIRECT = 25'sd4497972;
	localparam coef_t PINK_LAST   = 25'sd972458;
	localparam coef_t PINK_GAIN   = 25'sd922747;
	localparam coef_t BROWN_FEED  = 25'sd167772;
	localparam coef_t BROWN_LEAK  = 25'sd8371831;

	typedef logic [23:0] mag_tab_t [128];

	function automatic mag_tab_t build_mag_tab();
		mag_tab_t t;
		for (int i = 0; i < 128; i++) begin
			t[i] = 24'((i * COEF_ONE + 50) / 100);
		end
		return t;
	endfunction

	localparam mag_tab_t MAG_TAB = build_mag_tab();

	typedef enum logic [1:0] {
		REG_NOISE_COLOR  = 2'd0,
		REG_MIX_AMOUNT   = 2'd1,
		REG_BIAS_PERCENT = 2'd2,
		REG_SHELF_ALPHA  = 2'd3
	} cfg_reg_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOAD,
		ST_LO,
		ST_HI,
		ST_ACC,
		ST_POST
	} state_t;

	typedef enum logic [3:0] {
		OP_PINK_POLE,
		OP_PINK_FEED,
		OP_PINK_DIRECT,
		OP_PINK_LAST,
		OP_PINK_GAIN,
		OP_BROWN_FEED,
		OP_BROWN_LEAK,
		OP_SHELF_LP,
		OP_SHELF_KEEP,
		OP_SHELF_MAG,
		OP_MIX
	} op_t;

	typedef struct packed {
		logic load;
		logic lo;
		logic hi;
	} mul_ctl_t;

endpackage

### rtl/cnsm_mul.sv
// Shared signed coefficient multiplier, rounded Q1.23, split into two partial products.
`timescale 1ns / 1ps

module cnsm_mul #(
	parameter int STATE_WIDTH = cnsm_pkg::STATE_WIDTH_DEF
) (
	input  logic                                clk,
	input  cnsm_pkg::mul_ctl_t                  ctl,
	input  logic signed [STATE_WIDTH+3:0]       op_a,
	input  logic signed [cnsm_pkg::COEF_W-1:0]  op_c,
	output logic signed [STATE_WIDTH+3:0]       prod
);

	localparam int A_W  = STATE_WIDTH + 4;
	localparam int HI_W = A_W - 24;
	localparam int M_W  = (HI_W > 24) ? HI_W : 24;
	localparam int CW   = cnsm_pkg::COEF_W;

	logic [A_W-1:0]     ma_q;
	logic [23:0]        mc_q;
	logic               neg_q;
	logic [47:0]        plo_q;
	logic [HI_W+23:0]   phi_q;

	logic [M_W-1:0]     mul_a;
	logic [M_W+23:0]    mul_p;
	logic [48:0]        lo_rnd;
	logic [HI_W+25:0]   mag_sum;
	logic [A_W-1:0]     mag;

	assign mul_a = ctl.hi ? M_W'(ma_q[A_W-1:24]) : M_W'(ma_q[23:0]);
	assign mul_p = (M_W+24)'(mul_a) * (M_W+24)'(mc_q);

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			ma_q  <= op_a[A_W-1] ? (~op_a + 1'b1) : op_a;
			mc_q  <= op_c[CW-1] ? 24'(-op_c) : op_c[23:0];
			neg_q <= op_a[A_W-1] ^ op_c[CW-1];
		end
		if (ctl.lo) begin
			plo_q <= mul_p[47:0];
		end
		if (ctl.hi) begin
			phi_q <= mul_p[HI_W+23:0];
		end
	end

	always_comb begin
		lo_rnd  = {1'b0, plo_q} + 49'(1 << 22);
		mag_sum = (HI_W+26)'({phi_q, 1'b0}) + (HI_W+26)'(lo_rnd[48:23]);
		mag     = mag_sum[A_W-1:0];
		prod    = neg_q ? $signed(~mag + 1'b1) : $signed(mag);
	end

endmodule

### rtl/colored_noise_shaper_mixer.sv
// Top level: colored noise shaper and mixer with a shared multiplier sequencer.
//
// Channel   Dir  Handshake               Word
// s_axis    in   s_axis_tvalid/tready    tdata: dry_sample, white_sample
// m_axis    out  m_axis_tvalid/tready    tdata: mixed_sample
// cfg       in   cfg_valid/cfg_ready     cfg_index, cfg_data
//
// Each multiply on the shared multiplier steps through load, low half, high half,
// accumulate and update. A word is bypassed if mix_amount is below 7, else it runs
// N multiplies: 1 for white, 3 for brown, 16 for pink, plus 3 when bias is on.
// Reset clears all filter state, control and configuration; no clearing pass is needed.
// A finished word waits in the output register while the next non-bypass word is taken.
`timescale 1ns / 1ps

module colored_noise_shaper_mixer #(
	parameter int SAMPLE_WIDTH = cnsm_pkg::SAMPLE_WIDTH_DEF,
	parameter int STATE_WIDTH  = cnsm_pkg::STATE_WIDTH_DEF,
	localparam int IN_W  = ((2 * SAMPLE_WIDTH + 7) / 8) * 8,
	localparam int OUT_W = ((SAMPLE_WIDTH + 7) / 8) * 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_axis_tvalid,
	output logic             s_axis_tready,
	input  logic [IN_W-1:0]  s_axis_tdata,   // dry_sample, white_sample
	output logic             m_axis_tvalid,
	input  logic             m_axis_tready,
	output logic [OUT_W-1:0] m_axis_tdata,   // mixed_sample
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [1:0]       cfg_index,
	input  logic [15:0]      cfg_data
);

	localparam int SW      = STATE_WIDTH;
	localparam int SPW     = SAMPLE_WIDTH;
	localparam int A_W     = SW + 4;
	localparam int CW      = cnsm_pkg::COEF_W;
	localparam int GAP     = (SW - 4) - (SPW - 1);
	localparam int GAP_POS = (GAP > 0) ? GAP : 0;
	localparam int GAP_NEG = (GAP < 0) ? -GAP : 0;
	localparam int BIG_W   = ((SW > SPW) ? SW : SPW) + GAP_NEG + 8;

	localparam logic signed [BIG_W-1:0] ST_MAX = $signed({{(BIG_W-SW+1){1'b0}}, {(SW-1){1'b1}}});
	localparam logic signed [BIG_W-1:0] ST_MIN = ~ST_MAX;
	localparam logic signed [BIG_W-1:0] SP_MAX = $signed({{(BIG_W-SPW+1){1'b0}}, {(SPW-1){1'b1}}});
	localparam logic signed [BIG_W-1:0] SP_MIN = ~SP_MAX;

	function automatic logic signed [SW-1:0] sat_st(input logic signed [BIG_W-1:0] v);
		logic signed [SW-1:0] r;
		if (v > ST_MAX) r = ST_MAX[SW-1:0];
		else if (v < ST_MIN) r = ST_MIN[SW-1:0];
		else r = v[SW-1:0];
		return r;
	endfunction

	function automatic logic signed [SPW-1:0] sat_sp(input logic signed [BIG_W-1:0] v);
		logic signed [SPW-1:0] r;
		if (v > SP_MAX) r = SP_MAX[SPW-1:0];
		else if (v < SP_MIN) r = SP_MIN[SPW-1:0];
		else r = v[SPW-1:0];
		return r;
	endfunction

	function automatic logic signed [BIG_W-1:0] round_shift(
		input logic signed [BIG_W-1:0] v,
		input int k
	);
		logic [BIG_W-1:0] mag;
		logic [BIG_W-1:0] half;
		half = (k > 0) ? (BIG_W'(1) << (k - 1)) : '0;
		mag  = v[BIG_W-1] ? (~v + 1'b1) : v;
		mag  = (mag + half) >> k;
		return v[BIG_W-1] ? $signed(~mag + 1'b1) : $signed(mag);
	endfunction

	cnsm_pkg::state_t state_q, state_d;
	cnsm_pkg::op_t    op_q, op_next;
	cnsm_pkg::mul_ctl_t mul_ctl;

	logic [1:0]        color_q;
	logic [15:0]       mix_q;
	logic signed [7:0] bias_q;
	logic [15:0]       alpha_q;

	logic signed [SW-1:0] taps_q [cnsm_pkg::NUM_TAPS];
	logic signed [SW-1:0] brown_q;
	logic signed [SW-1:0] lp_q;
	logic [2:0]           idx_q;

	logic signed [SW-1:0]  w_q;
	logic signed [SPW-1:0] dry_q;
	logic signed [SW-1:0]  noise_q;
	logic signed [A_W-1:0] acc_q;
	logic signed [A_W-1:0] sum_q;

	logic             out_valid_q;
	logic [SPW-1:0]   out_data_q;

	logic                  in_acc;
	logic                  bypass;
	logic                  out_free;
	logic                  post_stall;
	logic signed [SPW-1:0] in_dry;
	logic signed [SPW-1:0] in_white;
	logic signed [SW-1:0]  w_state;
	logic [6:0]            bias_abs;
	logic                  bias_pos;
	logic [23:0]           shelf_mag;
	logic [23:0]           shelf_keep;
	logic signed [A_W-1:0] op_a;
	logic signed [CW-1:0]  op_c;
	logic signed [A_W-1:0] acc_init;
	logic signed [A_W-1:0] mul_r;
	logic signed [SW-1:0]  acc_sat;
	logic signed [BIG_W-1:0] seven_b;
	logic signed [SW-1:0]  brown_noise;
	logic signed [BIG_W-1:0] noise_smp;
	logic signed [SPW-1:0] mixed;
	cnsm_pkg::op_t         first_op;
	cnsm_pkg::op_t         after_color;

	assign cfg_ready     = 1'b1;
	assign in_dry        = $signed(s_axis_tdata[SPW-1:0]);
	assign in_white      = $signed(s_axis_tdata[2*SPW-1:SPW]);
	assign out_free      = !out_valid_q || m_axis_tready;
	assign s_axis_tready = (state_q == cnsm_pkg::ST_IDLE) && (out_free || !bypass);
	assign in_acc        = s_axis_tvalid && s_axis_tready;
	assign bypass        = mix_q < cnsm_pkg::AMOUNT_MIN;
	assign post_stall    = (op_q == cnsm_pkg::OP_MIX) && !out_free;
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = OUT_W'(out_data_q);

	cnsm_mul #(
		.STATE_WIDTH(STATE_WIDTH)
	) u_mul (
		.clk (clk),
		.ctl (mul_ctl),
		.op_a(op_a),
		.op_c(op_c),
		.prod(mul_r)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= cnsm_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		mul_ctl = '0;
		unique case (state_q)
			cnsm_pkg::ST_IDLE: begin
				if (in_acc && !bypass) state_d = cnsm_pkg::ST_LOAD;
			end
			cnsm_pkg::ST_LOAD: begin
				mul_ctl.load = 1'b1;
				state_d      = cnsm_pkg::ST_LO;
			end
			cnsm_pkg::ST_LO: begin
				mul_ctl.lo = 1'b1;
				state_d    = cnsm_pkg::ST_HI;
			end
			cnsm_pkg::ST_HI: begin
				mul_ctl.hi = 1'b1;
				state_d    = cnsm_pkg::ST_ACC;
			end
			cnsm_pkg::ST_ACC: begin
				state_d = cnsm_pkg::ST_POST;
			end
			cnsm_pkg::ST_POST: begin
				if (op_q == cnsm_pkg::OP_MIX) begin
					if (!post_stall) state_d = cnsm_pkg::ST_IDLE;
				end else begin
					state_d = cnsm_pkg::ST_LOAD;
				end
			end
			default: state_d = cnsm_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		if (bias_q < -8'sd100 || bias_q > 8'sd100) bias_abs = 7'(cnsm_pkg::BIAS_LIMIT);
		else if (bias_q[7]) bias_abs = 7'(-bias_q);
		else bias_abs = bias_q[6:0];
		bias_pos   = !bias_q[7] && (bias_q != 8'sd0);
		shelf_mag  = cnsm_pkg::MAG_TAB[bias_abs];
		shelf_keep = 24'(cnsm_pkg::COEF_ONE) - shelf_mag;

		if (GAP < 0) w_state = SW'(round_shift(BIG_W'(in_white), GAP_NEG));
		else w_state = SW'(BIG_W'(in_white) <<< GAP_POS);

		after_color = (bias_q != 8'sd0) ? cnsm_pkg::OP_SHELF_LP : cnsm_pkg::OP_MIX;
		case (color_q)
			cnsm_pkg::COLOR_PINK:  first_op = cnsm_pkg::OP_PINK_POLE;
			cnsm_pkg::COLOR_BROWN: first_op = cnsm_pkg::OP_BROWN_FEED;
			default:               first_op = after_color;
		endcase

		acc_sat     = sat_st(BIG_W'(acc_q));
		seven_b     = (BIG_W'(acc_sat) <<< 3) - BIG_W'(acc_sat);
		brown_noise = sat_st(round_shift(seven_b, 1));
		if (GAP < 0) noise_smp = BIG_W'(acc_sat) <<< GAP_NEG;
		else noise_smp = round_shift(BIG_W'(acc_sat), GAP_POS);
		mixed = sat_sp(noise_smp + BIG_W'(dry_q));

		op_a     = A_W'(w_q);
		op_c     = '0;
		acc_init = '0;
		op_next  = cnsm_pkg::OP_MIX;
		case (op_q)
			cnsm_pkg::OP_PINK_POLE: begin
				op_a    = A_W'(taps_q[idx_q]);
				op_c    = cnsm_pkg::POLE_COEF[idx_q];
				op_next = cnsm_pkg::OP_PINK_FEED;
			end
			cnsm_pkg::OP_PINK_FEED: begin
				op_c     = cnsm_pkg::FEED_COEF[idx_q];
				acc_init = acc_q;
				op_next  = (idx_q == 3'(cnsm_pkg::NUM_POLES - 1)) ?
					cnsm_pkg::OP_PINK_DIRECT : cnsm_pkg::OP_PINK_POLE;
			end
			cnsm_pkg::OP_PINK_DIRECT: begin
				op_c     = cnsm_pkg::PINK_DIRECT;
				acc_init = sum_q + A_W'(taps_q[cnsm_pkg::NUM_TAPS-1]);
				op_next  = cnsm_pkg::OP_PINK_LAST;
			end
			cnsm_pkg::OP_PINK_LAST: begin
				op_c    = cnsm_pkg::PINK_LAST;
				op_next = cnsm_pkg::OP_PINK_GAIN;
			end
			cnsm_pkg::OP_PINK_GAIN: begin
				op_a    = sum_q;
				op_c    = cnsm_pkg::PINK_GAIN;
				op_next = after_color;
			end
			cnsm_pkg::OP_BROWN_FEED: begin
				op_c     = cnsm_pkg::BROWN_FEED;
				acc_init = A_W'(brown_q);
				op_next  = cnsm_pkg::OP_BROWN_LEAK;
			end
			cnsm_pkg::OP_BROWN_LEAK: begin
				op_a    = acc_q;
				op_c    = cnsm_pkg::BROWN_LEAK;
				op_next = after_color;
			end
			cnsm_pkg::OP_SHELF_LP: begin
				op_a     = A_W'(noise_q) - A_W'(lp_q);
				op_c     = CW'({alpha_q, 7'b0});
				acc_init = A_W'(lp_q);
				op_next  = cnsm_pkg::OP_SHELF_KEEP;
			end
			cnsm_pkg::OP_SHELF_KEEP: begin
				op_a    = A_W'(noise_q);
				op_c    = CW'(shelf_keep);
				op_next = cnsm_pkg::OP_SHELF_MAG;
			end
			cnsm_pkg::OP_SHELF_MAG: begin
				op_a     = bias_pos ? (A_W'(noise_q) - A_W'(lp_q)) : A_W'(lp_q);
				op_c     = CW'(shelf_mag);
				acc_init = acc_q;
				op_next  = cnsm_pkg::OP_MIX;
			end
			cnsm_pkg::OP_MIX: begin
				op_a    = A_W'(noise_q);
				op_c    = CW'({mix_q, 5'b0});
				op_next = cnsm_pkg::OP_MIX;
			end
			default: op_next = cnsm_pkg::OP_MIX;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			color_q     <= cnsm_pkg::COLOR_WHITE;
			mix_q       <= '0;
			bias_q      <= '0;
			alpha_q     <= cnsm_pkg::ALPHA_RESET;
			for (int i = 0; i < cnsm_pkg::NUM_TAPS; i++) taps_q[i] <= '0;
			brown_q     <= '0;
			lp_q        <= '0;
			idx_q       <= '0;
			op_q        <= cnsm_pkg::OP_MIX;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				unique case (cnsm_pkg::cfg_reg_t'(cfg_index))
					cnsm_pkg::REG_NOISE_COLOR:  color_q <= cfg_data[1:0];
					cnsm_pkg::REG_MIX_AMOUNT:   mix_q   <= cfg_data;
					cnsm_pkg::REG_BIAS_PERCENT: bias_q  <= $signed(cfg_data[7:0]);
					cnsm_pkg::REG_SHELF_ALPHA:  alpha_q <= cfg_data;
					default: ;
				endcase
			end

			if (m_axis_tready) out_valid_q <= 1'b0;

			if (in_acc) begin
				idx_q <= '0;
				op_q  <= first_op;
				if (bypass) out_valid_q <= 1'b1;
			end

			if (state_q == cnsm_pkg::ST_POST && !post_stall) begin
				op_q <= op_next;
				case (op_q)
					cnsm_pkg::OP_PINK_FEED: begin
						taps_q[idx_q] <= acc_sat;
						if (idx_q != 3'(cnsm_pkg::NUM_POLES - 1)) idx_q <= idx_q + 3'd1;
					end
					cnsm_pkg::OP_PINK_LAST:  taps_q[cnsm_pkg::NUM_TAPS-1] <= acc_sat;
					cnsm_pkg::OP_BROWN_LEAK: brown_q <= acc_sat;
					cnsm_pkg::OP_SHELF_LP:   lp_q <= acc_sat;
					cnsm_pkg::OP_MIX:        out_valid_q <= 1'b1;
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			dry_q   <= in_dry;
			w_q     <= w_state;
			noise_q <= w_state;
			sum_q   <= '0;
			if (bypass) out_data_q <= in_dry;
		end
		if (state_q == cnsm_pkg::ST_LOAD) acc_q <= acc_init;
		if (state_q == cnsm_pkg::ST_ACC) acc_q <= acc_q + mul_r;
		if (state_q == cnsm_pkg::ST_POST && !post_stall) begin
			case (op_q)
				cnsm_pkg::OP_PINK_FEED:   sum_q <= sum_q + A_W'(acc_sat);
				cnsm_pkg::OP_PINK_DIRECT: sum_q <= acc_q;
				cnsm_pkg::OP_PINK_GAIN:   noise_q <= acc_sat;
				cnsm_pkg::OP_BROWN_LEAK:  noise_q <= brown_noise;
				cnsm_pkg::OP_SHELF_MAG:   noise_q <= acc_sat;
				cnsm_pkg::OP_MIX:         out_data_q <= mixed;
				default: ;
			endcase
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready && mix_q < cnsm_pkg::AMOUNT_MIN) |=>
		(m_axis_tvalid && m_axis_tdata[SPW-1:0] == $past(s_axis_tdata[SPW-1:0])))
		else $error("bypass word not passed through");

	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |->
		($past(state_q) == cnsm_pkg::ST_POST || $past(s_axis_tvalid && s_axis_tready)))
		else $error("output word without finished work");

	assert property (@(posedge clk) disable iff (!arst_n)
		(op_q == cnsm_pkg::OP_PINK_POLE || op_q == cnsm_pkg::OP_PINK_FEED) |->
		(idx_q < 3'(cnsm_pkg::NUM_POLES)))
		else $error("pink tap index out of range");

	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == cnsm_pkg::ST_POST && op_q == cnsm_pkg::OP_MIX && !post_stall) |=>
		(m_axis_tvalid && state_q == cnsm_pkg::ST_IDLE))
		else $error("final multiply did not deliver a word");

endmodule

### bench/colored_noise_shaper_mixer_test.sv
// Self-checking bench for the colored noise shaper and mixer with a bit-exact predictor.
`timescale 1ns / 1ps

module colored_noise_shaper_mixer_test;

	localparam logic [23:0] SAMPLE_MAX  = 24'h7FFFFF;
	localparam logic [23:0] SAMPLE_MIN  = 24'h800000;
	localparam logic [1:0]  COLOR_SPARE = 2'd3;
	localparam logic [15:0] MIN_AMOUNT  = 16'd7;
	localparam logic [15:0] ALPHA_500HZ = 16'd4025;
	localparam longint      UNITY       = 8388608;
	localparam int          QUIET_LIMIT = 4000;
	localparam int          RAND_PHASES = 32;
	localparam int          PHASE_WORDS = 40;

	class shaper_board;
		logic [1:0]        color;
		logic [15:0]       amount;
		logic signed [7:0] bias;
		logic [15:0]       alpha;
		longint            taps [7];
		longint            brown;
		longint            lowpass;
		logic [23:0]       mixed_due [$];
		int                errors;
		int                checked;

		function new();
			color = cnsm_pkg::COLOR_WHITE;
			amount = '0;
			bias = '0;
			alpha = ALPHA_500HZ;
			foreach (taps[i]) taps[i] = 0;
			brown = 0;
			lowpass = 0;
			errors = 0;
			checked = 0;
		endfunction

		function void set_reg(logic [1:0] idx, logic [15:0] data);
			case (idx)
				cnsm_pkg::REG_NOISE_COLOR:  color = data[1:0];
				cnsm_pkg::REG_MIX_AMOUNT:   amount = data;
				cnsm_pkg::REG_BIAS_PERCENT: bias = data[7:0];
				cnsm_pkg::REG_SHELF_ALPHA:  alpha = data;
				default: ;
			endcase
		endfunction

		function longint sat_to(longint v, int w);
			longint hi, lo;
			hi = (64'sd1 <<< (w - 1)) - 1;
			lo = -hi - 1;
			if (v > hi) return hi;
			if (v < lo) return lo;
			return v;
		endfunction

		function longint sat_st(longint v);
			return sat_to(v, 32);
		endfunction

		function longint round_shift(longint v, int k);
			longint unsigned mag;
			longint          r;
			bit              neg;
			if (k <= 0) return v;
			neg = v < 0;
			mag = neg ? -v : v;
			mag = (mag + (64'd1 << (k - 1))) >> k;
			r = mag;
			return neg ? -r : r;
		endfunction

		function longint coef_mul(longint a, longint c);
			longint unsigned ma, mc, hi, lo, r;
			longint          s;
			bit              neg;
			neg = (a < 0) != (c < 0);
			ma = (a < 0) ? -a : a;
			mc = (c < 0) ? -c : c;
			hi = ma >> 24;
			lo = ma & 64'hFFFFFF;
			r = ((hi * mc) << 1) + ((lo * mc + 64'd4194304) >> 23);
			s = r;
			return neg ? -s : s;
		endfunction

		function longint pole_k(int i);
			case (i)
				0: return 8379045;
				1: return 8332572;
				2: return 8128561;
				3: return 7268729;
				4: return 4613734;
				default: return -6388764;
			endcase
		endfunction

		function longint feed_k(int i);
			case (i)
				0: return 465718;
				1: return 629782;
				2: return 1290604;
				3: return 2604542;
				4: return 4470727;
				default: return -141751;
			endcase
		endfunction

		function longint pink_noise(longint w);
			longint sum;
			sum = 0;
			for (int i = 0; i < 6; i++) begin
				taps[i] = sat_st(coef_mul(taps[i], pole_k(i)) + coef_mul(w, feed_k(i)));
				sum += taps[i];
			end
			sum += taps[6] + coef_mul(w, 4497972);
			taps[6] = sat_st(coef_mul(w, 972458));
			return sat_st(coef_mul(sum, 922747));
		endfunction

		function longint brown_noise(longint w);
			longint b;
			b = brown + coef_mul(w, 167772);
			brown = sat_st(coef_mul(b, 8371831));
			return sat_st(brown * 3 + round_shift(brown, 1));
		endfunction

		function longint shelf(longint x);
			longint b, mag, keep, lp, other;
			b = bias;
			if (b > 100) b = 100;
			if (b < -100) b = -100;
			if (b == 0) return x;
			mag = (b < 0) ? -b : b;
			mag = (mag * UNITY + 50) / 100;
			keep = UNITY - mag;
			lp = sat_st(lowpass + coef_mul(x - lowpass, longint'(alpha) << 7));
			lowpass = lp;
			other = (b > 0) ? (x - lp) : lp;
			return sat_st(coef_mul(x, keep) + coef_mul(other, mag));
		endfunction

		function logic [23:0] predict_mix(logic [23:0] dry_bits, logic [23:0] white_bits);
			longint dry, w, noise, res;
			dry = $signed(dry_bits);
			if (amount < MIN_AMOUNT) return dry_bits;
			w = $signed(white_bits);
			w = w * 32;
			case (color)
				cnsm_pkg::COLOR_PINK:  noise = pink_noise(w);
				cnsm_pkg::COLOR_BROWN: noise = brown_noise(w);
				default:               noise = sat_st(w);
			endcase
			noise = shelf(noise);
			noise = sat_st(coef_mul(noise, longint'(amount) << 5));
			res = sat_to(dry + round_shift(noise, 5), 24);
			return res[23:0];
		endfunction

		function void note_input(logic [47:0] word);
			mixed_due.push_back(predict_mix(word[23:0], word[47:24]));
		endfunction

		function int pending();
			return mixed_due.size();
		endfunction

		task report(string what);
			errors++;
			if (errors <= 100) $display("mismatch: %s", what);
		endtask

		task check_mixed(logic [23:0] got);
			logic [23:0] want;
			if (mixed_due.size() == 0) begin
				report($sformatf("output word %h with none due", got));
			end else begin
				want = mixed_due.pop_front();
				if (got !== want)
					report($sformatf("word %0d: mixed_sample %h, want %h", checked, got, want));
				checked++;
			end
		endtask
	endclass

	logic        clk;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [47:0] s_axis_tdata = '0;   // dry_sample, white_sample
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [23:0] m_axis_tdata;        // mixed_sample
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [1:0]  cfg_index = '0;
	logic [15:0] cfg_data = '0;

	shaper_board sb = new();
	bit          calm = 1'b0;
	bit          pressure_done = 1'b0;
	int          out_count = 0;
	int          quiet = 0;

	colored_noise_shaper_mixer u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	always @(posedge clk) begin
		if (cfg_valid && cfg_ready) sb.set_reg(cfg_index, cfg_data);
		if (s_axis_tvalid && s_axis_tready) sb.note_input(s_axis_tdata);
		if (m_axis_tvalid && m_axis_tready) begin
			sb.check_mixed(m_axis_tdata);
			out_count++;
		end
		if ((cfg_valid && cfg_ready) || (s_axis_tvalid && s_axis_tready) ||
		    (m_axis_tvalid && m_axis_tready))
			quiet = 0;
		else
			quiet++;
		if (quiet >= QUIET_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	// receiver: random ready bursts, one long hold-off to back the block up
	initial begin
		forever begin
			if (!pressure_done && out_count >= 150) begin
				m_axis_tready <= 1'b0;
				repeat (600) @(posedge clk);
				pressure_done = 1'b1;
			end else if (calm) begin
				m_axis_tready <= 1'b1;
				@(posedge clk);
			end else begin
				m_axis_tready <= ($urandom_range(0, 2) != 0);
				repeat ($urandom_range(1, 8)) @(posedge clk);
			end
		end
	end

	task send_sample(logic [23:0] dry, logic [23:0] white);
		s_axis_tdata <= {white, dry};
		s_axis_tvalid <= 1'b1;
		do @(posedge clk); while (!s_axis_tready);
		if (!calm && $urandom_range(0, 3) == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
	endtask

	task drain_block(int settle);
		s_axis_tvalid <= 1'b0;
		do @(posedge clk); while (sb.pending() != 0);
		repeat (settle) @(posedge clk);
	endtask

	task write_reg(cnsm_pkg::cfg_reg_t idx, logic [15:0] data);
		cfg_index <= idx;
		cfg_data <= data;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
	endtask

	task apply_setting(logic [1:0] color, logic [15:0] amount, logic [7:0] bias,
	                   logic [15:0] alpha);
		logic [15:0] junk;
		drain_block(8);
		junk = 16'($urandom);
		write_reg(cnsm_pkg::REG_NOISE_COLOR, {junk[15:2], color});
		write_reg(cnsm_pkg::REG_MIX_AMOUNT, amount);
		junk = 16'($urandom);
		write_reg(cnsm_pkg::REG_BIAS_PERCENT, {junk[15:8], bias});
		write_reg(cnsm_pkg::REG_SHELF_ALPHA, alpha);
		cfg_valid <= 1'b0;
	endtask

	task random_phase(int count);
		logic [1:0]  color;
		logic [15:0] amount, alpha;
		logic [7:0]  bias;
		logic [23:0] dry, white;
		int          style;
		color = 2'($urandom_range(0, 3));
		case ($urandom_range(0, 9))
			0:       amount = 16'($urandom_range(0, MIN_AMOUNT - 1));
			1:       amount = MIN_AMOUNT;
			2:       amount = 16'hFFFF;
			default: amount = 16'($urandom_range(MIN_AMOUNT, 65535));
		endcase
		case ($urandom_range(0, 7))
			0:       bias = 8'd0;
			1:       bias = 8'd100;
			2:       bias = 8'h9C;
			3:       bias = 8'($urandom);
			default: bias = 8'($urandom_range(0, 200) - 100);
		endcase
		case ($urandom_range(0, 4))
			0:       alpha = 16'd0;
			1:       alpha = 16'hFFFF;
			2:       alpha = ALPHA_500HZ;
			default: alpha = 16'($urandom);
		endcase
		apply_setting(color, amount, bias, alpha);
		style = $urandom_range(0, 3);
		repeat (count) begin
			dry = 24'($urandom);
			white = 24'($urandom);
			if (style == 2) white = 24'($urandom_range(0, 2047) - 1024);
			if (style == 3) begin
				white = $urandom_range(0, 1) ? SAMPLE_MAX : SAMPLE_MIN;
				if ($urandom_range(0, 1)) dry = white;
			end
			send_sample(dry, white);
		end
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset defaults: amount zero, pass through
		send_sample(SAMPLE_MAX, SAMPLE_MAX);
		send_sample(SAMPLE_MIN, SAMPLE_MIN);

		apply_setting(cnsm_pkg::COLOR_WHITE, MIN_AMOUNT - 16'd1, 8'd0, ALPHA_500HZ);
		send_sample(SAMPLE_MAX, SAMPLE_MIN);

		apply_setting(cnsm_pkg::COLOR_WHITE, MIN_AMOUNT, 8'd0, ALPHA_500HZ);
		send_sample(24'd0, SAMPLE_MAX);
		send_sample(24'd0, SAMPLE_MIN);
		send_sample(24'hFFFFFF, 24'hFFFFFF);

		apply_setting(cnsm_pkg::COLOR_WHITE, 16'hFFFF, 8'd0, ALPHA_500HZ);
		send_sample(SAMPLE_MAX, SAMPLE_MAX);
		send_sample(SAMPLE_MIN, SAMPLE_MIN);
		send_sample(SAMPLE_MAX, SAMPLE_MIN);

		apply_setting(cnsm_pkg::COLOR_PINK, 16'hFFFF, 8'd100, 16'hFFFF);
		send_sample(24'd0, SAMPLE_MAX);
		send_sample(SAMPLE_MAX, SAMPLE_MAX);
		send_sample(24'd0, SAMPLE_MIN);

		apply_setting(cnsm_pkg::COLOR_BROWN, 16'd40000, 8'h9C, 16'd0);
		send_sample(24'd0, SAMPLE_MAX);
		send_sample(24'd0, SAMPLE_MAX);
		send_sample(SAMPLE_MIN, SAMPLE_MIN);

		apply_setting(COLOR_SPARE, 16'd30000, 8'h7F, ALPHA_500HZ);
		send_sample(24'd0, SAMPLE_MAX);
		send_sample(24'd1, SAMPLE_MIN);

		apply_setting(cnsm_pkg::COLOR_PINK, 16'd20000, 8'h80, 16'd1000);
		send_sample(24'd0, SAMPLE_MIN);
		send_sample(SAMPLE_MAX, SAMPLE_MAX);

		apply_setting(cnsm_pkg::COLOR_BROWN, 16'hFFFF, 8'd50, 16'hFFFF);
		send_sample(24'd0, SAMPLE_MAX);
		send_sample(SAMPLE_MIN, SAMPLE_MAX);

		for (int phase = 0; phase < RAND_PHASES; phase++) begin
			if (phase >= RAND_PHASES - 4) calm = 1'b1;
			random_phase(PHASE_WORDS);
		end

		drain_block(120);
		if (sb.errors == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

### colored_noise_shaper_mixer.f
rtl/cnsm_pkg.sv
rtl/cnsm_mul.sv
rtl/colored_noise_shaper_mixer.sv
bench/colored_noise_shaper_mixer_test.sv
